// ===== sv/ptw_pkg.sv =====
// shared types, widths and codes for the four-level page table walker
package ptw_pkg;

  localparam int VA_W    = 48;
  localparam int FRAME_W = 40;
  localparam int ADDR_W  = 52;
  localparam int ROOT_W  = 64;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] PAGE_4K = 2'd0;
  localparam logic [1:0] PAGE_2M = 2'd1;
  localparam logic [1:0] PAGE_1G = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISS_L4   = 3'd1;
  localparam logic [2:0] ST_MISS_L3   = 3'd2;
  localparam logic [2:0] ST_MISS_L2   = 3'd3;
  localparam logic [2:0] ST_MISS_L1   = 3'd4;
  localparam logic [2:0] ST_SELF_MAP  = 3'd5;
  localparam logic [2:0] ST_ZERO_FRM  = 3'd6;
  localparam logic [2:0] ST_UNEXP_DAT = 3'd7;

  localparam logic [1:0] LVL_PML4 = 2'd3;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PT   = 2'd0;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef struct packed {
    logic                 cmd;
    logic [ROOT_W-1:0]    root;
    logic [VA_W-1:0]      virt_addr;
    logic [ENTRY_W-1:0]   entry;
    logic                 read_failed;
  } in_item_t;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_W-1:0]    address;
    logic [1:0]           pg_size;
    logic [2:0]           status;
  } out_item_t;

  typedef struct packed {
    logic                 busy;
    logic [1:0]           level;
    logic [VA_W-1:0]      walk_addr;
    logic [FRAME_W-1:0]   root_frame;
  } walk_state_t;

endpackage

// ===== sv/ptw_step.sv =====
// combinational next-state and result logic for one walker item
module ptw_step import ptw_pkg::*; (
  input  in_item_t          item,
  input  walk_state_t       state,
  input  logic [ROOT_W-1:0] default_root,
  output out_item_t         result,
  output walk_state_t       state_nxt
);

  logic [ROOT_W-1:0]  cr3;
  logic [FRAME_W-1:0] new_root;
  logic [FRAME_W-1:0] frame;
  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  phys_1g;
  logic [ADDR_W-1:0]  phys_2m;
  logic [ADDR_W-1:0]  phys_4k;
  logic [2:0]         miss_status;
  logic               present;
  logic               big_page;

  assign cr3      = (item.root != '0) ? item.root : default_root;
  assign new_root = cr3[12 +: FRAME_W];
  assign frame    = item.entry[12 +: FRAME_W];
  assign present  = item.entry[BIT_PRESENT] && !item.read_failed;
  assign big_page = item.entry[BIT_LARGE];

  assign phys_1g = {item.entry[51:30], state.walk_addr[29:0]};
  assign phys_2m = {item.entry[51:21], state.walk_addr[20:0]};
  assign phys_4k = {item.entry[51:12], state.walk_addr[11:0]};

  // index of the next table entry, taken from the latched address
  always_comb begin
    unique case (state.level)
      LVL_PML4: idx = state.walk_addr[30 +: IDX_W];
      LVL_PDPT: idx = state.walk_addr[21 +: IDX_W];
      default:  idx = state.walk_addr[12 +: IDX_W];
    endcase
  end

  always_comb begin
    unique case (state.level)
      LVL_PML4: miss_status = ST_MISS_L4;
      LVL_PDPT: miss_status = ST_MISS_L3;
      LVL_PD:   miss_status = ST_MISS_L2;
      default:  miss_status = ST_MISS_L1;
    endcase
  end

  always_comb begin
    state_nxt        = state;
    result.kind      = KIND_DONE;
    result.address   = '0;
    result.pg_size   = PAGE_4K;
    result.status    = ST_OK;

    priority if (item.cmd == CMD_START) begin
      state_nxt.busy       = 1'b1;
      state_nxt.level      = LVL_PML4;
      state_nxt.walk_addr  = item.virt_addr;
      state_nxt.root_frame = new_root;
      result.kind          = KIND_READ;
      result.address       = {new_root, item.virt_addr[39 +: IDX_W], 3'b000};
    end else if (!state.busy) begin
      result.status = ST_UNEXP_DAT;
    end else if (!present) begin
      state_nxt.busy  = 1'b0;
      state_nxt.level = LVL_PT;
      result.status   = miss_status;
    end else begin
      unique case (state.level)
        LVL_PML4: begin
          if (frame == state.root_frame) begin
            state_nxt.busy  = 1'b0;
            state_nxt.level = LVL_PT;
            result.status   = ST_SELF_MAP;
          end else begin
            state_nxt.level = LVL_PDPT;
            result.kind     = KIND_READ;
            result.address  = {frame, idx, 3'b000};
          end
        end
        LVL_PDPT: begin
          if (big_page) begin
            state_nxt.busy  = 1'b0;
            state_nxt.level = LVL_PT;
            if (item.entry[51:30] == '0) begin
              result.status = ST_ZERO_FRM;
            end else begin
              result.address = phys_1g;
              result.pg_size = PAGE_1G;
            end
          end else begin
            state_nxt.level = LVL_PD;
            result.kind     = KIND_READ;
            result.address  = {frame, idx, 3'b000};
          end
        end
        LVL_PD: begin
          if (big_page) begin
            state_nxt.busy  = 1'b0;
            state_nxt.level = LVL_PT;
            if (item.entry[51:21] == '0) begin
              result.status = ST_ZERO_FRM;
            end else begin
              result.address = phys_2m;
              result.pg_size = PAGE_2M;
            end
          end else begin
            state_nxt.level = LVL_PT;
            result.kind     = KIND_READ;
            result.address  = {frame, idx, 3'b000};
          end
        end
        default: begin
          state_nxt.busy  = 1'b0;
          state_nxt.level = LVL_PT;
          if (frame == '0) begin
            result.status = ST_ZERO_FRM;
          end else begin
            result.address = phys_4k;
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/x86_64_page_table_walker.sv =====
// four-level page table walker: one item in, one result item out
// the result is registered and shows on out_valid in the cycle after the input is accepted
// throughput: one item per cycle while out_ready is high, set by the single output
//   register; the next item is taken in the same cycle the held result is taken
// reset (rst_n low, synchronous): idle, level 0, no result held, default root 0
module x86_64_page_table_walker import ptw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [ROOT_W-1:0] cfg_data
);

  walk_state_t       state_r;
  walk_state_t       state_nxt;
  out_item_t         out_item_r;
  out_item_t         result;
  logic              out_valid_r;
  logic [ROOT_W-1:0] default_root_r;
  logic              in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  ptw_step u_step (
    .item         (in_item),
    .state        (state_r),
    .default_root (default_root_r),
    .result       (result),
    .state_nxt    (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= '0;
      out_valid_r    <= 1'b0;
      default_root_r <= '0;
    end else begin
      if (cfg_we) begin
        default_root_r <= cfg_data;
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only on accept
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= result;
    end
  end

endmodule
